@@ rtl/rcf_pkg.sv @@
// ---------------------------------------------------------------------------
// rcf_pkg: shared types and constants for the RC channel frame block
// Channel scaling constants, register indexes, pipeline enables and the
// CRC-16 column tables used by the frame CRC merge.
// ---------------------------------------------------------------------------
`default_nettype none

package rcf_pkg;

    localparam int AXIS_W   = 16;
    localparam int CH_W     = 11;
    localparam int WORD_W   = 16;
    localparam int N_LANES  = 7;
    localparam int N_WORDS  = 10;
    localparam int PROD_W   = AXIS_W + CH_W;

    localparam logic [WORD_W-1:0] CRC_POLY   = 16'h1021;
    localparam logic [CH_W-1:0]   CH_MIN_RST = 11'd191;
    localparam logic [CH_W-1:0]   CH_MAX_RST = 11'd1792;

    // configuration register indexes
    localparam logic CFG_CH_MIN = 1'b0;
    localparam logic CFG_CH_MAX = 1'b1;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    typedef logic [N_WORDS-1:0][WORD_W-1:0]              t_frame_words;
    typedef logic [N_WORDS-1:0][WORD_W-1:0][WORD_W-1:0]  t_crc_cols;

    // Column j of word k: CRC contribution of bit j of word k, i.e. that bit
    // pushed through the zero-data shift for its own word and all that follow.
    // Evaluated at elaboration only.
    function automatic t_crc_cols crc_cols();
        t_crc_cols cols;
        logic [WORD_W-1:0] c;
        for (int k = 0; k < N_WORDS; k++) begin
            for (int j = 0; j < WORD_W; j++) begin
                c = WORD_W'(1) << j;
                for (int s = 0; s < WORD_W * (N_WORDS - k); s++) begin
                    c = {c[WORD_W-2:0], 1'b0} ^ (c[WORD_W-1] ? CRC_POLY : '0);
                end
                cols[k][j] = c;
            end
        end
        return cols;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rcf_scale_lane.sv @@
// ---------------------------------------------------------------------------
// rcf_scale_lane: one axis-to-channel scaling lane
// value = min + floor((x*span + 32767) / 65535), x = axis + 32768.
// Three registered steps: offset axis, product, quotient and offset.
// ---------------------------------------------------------------------------
`default_nettype none

module rcf_scale_lane (
    input  wire logic                           i_clk,
    input  wire rcf_pkg::t_pipe_en              i_en,
    input  wire logic signed [rcf_pkg::AXIS_W-1:0] i_axis,
    input  wire logic [rcf_pkg::CH_W-1:0]       i_span,
    input  wire logic [rcf_pkg::CH_W-1:0]       i_min,
    output logic [rcf_pkg::CH_W-1:0]            o_value
);

    logic [rcf_pkg::AXIS_W-1:0] r_x;
    logic [rcf_pkg::PROD_W-1:0] r_prod;
    logic [rcf_pkg::CH_W-1:0]   r_value;

    logic [rcf_pkg::PROD_W-1:0] w_m;
    logic [rcf_pkg::CH_W-1:0]   w_hi;
    logic [16:0]                w_rem;
    logic                       w_ge;
    logic [rcf_pkg::CH_W-1:0]   n_value;

    // divide by 2^16-1: m = hi*65535 + (hi + lo), and hi + lo < 2*65535
    always_comb begin
        w_m     = r_prod + rcf_pkg::PROD_W'(32767);
        w_hi    = w_m[rcf_pkg::PROD_W-1:16];
        w_rem   = {6'b0, w_hi} + {1'b0, w_m[15:0]};
        w_ge    = (w_rem >= 17'd65535);
        n_value = i_min + (w_hi + {{(rcf_pkg::CH_W-1){1'b0}}, w_ge});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_x <= {~i_axis[rcf_pkg::AXIS_W-1], i_axis[rcf_pkg::AXIS_W-2:0]};
        end
        if (i_en.s2) begin
            r_prod <= {{rcf_pkg::CH_W{1'b0}}, r_x} * {{rcf_pkg::AXIS_W{1'b0}}, i_span};
        end
        if (i_en.s3) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

@@ rtl/rcf_crc_merge.sv @@
// ---------------------------------------------------------------------------
// rcf_crc_merge: frame CRC-16 merge stage
// CRC (poly 0x1021, init 0, MSB first) is linear, so each word contributes
// an independent XOR term; the terms are merged and registered.
// ---------------------------------------------------------------------------
`default_nettype none

module rcf_crc_merge (
    input  wire logic                       i_clk,
    input  wire rcf_pkg::t_pipe_en          i_en,
    input  wire rcf_pkg::t_frame_words      i_words,
    output logic [rcf_pkg::WORD_W-1:0]      o_crc
);

    localparam rcf_pkg::t_crc_cols CRC_COLS = rcf_pkg::crc_cols();

    logic [rcf_pkg::N_WORDS-1:0][rcf_pkg::WORD_W-1:0] w_term;
    logic [rcf_pkg::WORD_W-1:0] n_crc;
    logic [rcf_pkg::WORD_W-1:0] r_crc;

    always_comb begin
        for (int k = 0; k < rcf_pkg::N_WORDS; k++) begin
            w_term[k] = '0;
            for (int j = 0; j < rcf_pkg::WORD_W; j++) begin
                w_term[k] = w_term[k] ^ (i_words[k][j] ? CRC_COLS[k][j] : '0);
            end
        end
        n_crc = '0;
        for (int k = 0; k < rcf_pkg::N_WORDS; k++) begin
            n_crc = n_crc ^ w_term[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

@@ rtl/rc_channel_frame_crc16.sv @@
// Each poll passes the s1, s2, s3 and s4 registers in turn to o_out_valid.
// Throughput: one poll per cycle unless the output stalls; stages advance
// independently; bubbles fill while a result waits in the output register.
// Scaling runs in seven parallel lanes (offset, 27-bit product, quotient).
// Reset (i_rst_n low, synchronous) clears pipeline valids, packet counter,
// failsafe mode and button history, and loads channel min/max 191/1792.
// ---------------------------------------------------------------------------
// rc_channel_frame_crc16: RC poll to channel frame with CRC-16
// Counts packets, toggles failsafe on button rising edge, scales the axes
// and appends a CRC over the ten frame words.
// ---------------------------------------------------------------------------
`default_nettype none

module rc_channel_frame_crc16 (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_index,
    input  wire logic [rcf_pkg::CH_W-1:0]          i_cfg_data,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [rcf_pkg::AXIS_W-1:0] i_axis_0,
    input  wire logic signed [rcf_pkg::AXIS_W-1:0] i_axis_1,
    input  wire logic signed [rcf_pkg::AXIS_W-1:0] i_axis_2,
    input  wire logic signed [rcf_pkg::AXIS_W-1:0] i_axis_3,
    input  wire logic signed [rcf_pkg::AXIS_W-1:0] i_axis_4,
    input  wire logic signed [rcf_pkg::AXIS_W-1:0] i_axis_5,
    input  wire logic signed [rcf_pkg::AXIS_W-1:0] i_axis_6,
    input  wire logic signed [rcf_pkg::AXIS_W-1:0] i_axis_7,
    input  wire logic                              i_button_toggle,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [rcf_pkg::WORD_W-1:0]             o_packet_number,
    output logic [rcf_pkg::CH_W-1:0]               o_ch1_scaled,
    output logic [rcf_pkg::CH_W-1:0]               o_ch2_scaled,
    output logic [rcf_pkg::CH_W-1:0]               o_ch3_scaled,
    output logic [rcf_pkg::CH_W-1:0]               o_ch4_scaled,
    output logic [rcf_pkg::CH_W-1:0]               o_ch5_scaled,
    output logic [rcf_pkg::CH_W-1:0]               o_ch6_scaled,
    output logic [rcf_pkg::CH_W-1:0]               o_ch7_scaled,
    output logic                                   o_remote_flag,
    output logic                                   o_failsafe_flag,
    output logic [rcf_pkg::WORD_W-1:0]             o_frame_crc
);

    // configuration
    logic [rcf_pkg::CH_W-1:0] r_ch_min;
    logic [rcf_pkg::CH_W-1:0] r_ch_max;
    logic [rcf_pkg::CH_W-1:0] w_span;

    // poll state
    logic [rcf_pkg::WORD_W-1:0] r_packet_counter;
    logic [rcf_pkg::WORD_W-1:0] n_packet_counter;
    logic                       r_failsafe;
    logic                       n_failsafe;
    logic                       r_last_button;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    rcf_pkg::t_pipe_en w_en;

    // per-request side data carried alongside the lanes
    logic [rcf_pkg::WORD_W-1:0] r1_cnt, r2_cnt, r3_cnt, r4_cnt;
    logic r1_fs, r2_fs, r3_fs, r4_fs;
    logic r1_rem, r2_rem, r3_rem, r4_rem;

    logic [rcf_pkg::N_LANES-1:0][rcf_pkg::AXIS_W-1:0] w_axes;
    logic [rcf_pkg::N_LANES-1:0][rcf_pkg::CH_W-1:0]   w_lane_val;
    logic [rcf_pkg::N_LANES-1:0][rcf_pkg::CH_W-1:0]   r_ch;
    rcf_pkg::t_frame_words w_words;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_min <= rcf_pkg::CH_MIN_RST;
            r_ch_max <= rcf_pkg::CH_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rcf_pkg::CFG_CH_MIN: begin
                    r_ch_min <= i_cfg_data;
                end
                rcf_pkg::CFG_CH_MAX: begin
                    r_ch_max <= i_cfg_data;
                end
                default: begin
                    r_ch_min <= r_ch_min;
                end
            endcase
        end
    end

    // max below min collapses every channel onto min
    assign w_span = (r_ch_max > r_ch_min) ? (r_ch_max - r_ch_min) : '0;

    assign w_rdy4 = !r_v4 || i_out_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    always_comb begin
        w_en.s1 = i_in_valid && w_rdy1;
        w_en.s2 = r_v1 && w_rdy2;
        w_en.s3 = r_v2 && w_rdy3;
        w_en.s4 = r_v3 && w_rdy4;
    end

    always_comb begin
        n_packet_counter = r_packet_counter + 1'b1;
        n_failsafe       = r_failsafe ^ (i_button_toggle && !r_last_button);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_v3             <= 1'b0;
            r_v4             <= 1'b0;
            r_packet_counter <= '0;
            r_failsafe       <= 1'b0;
            r_last_button    <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_en.s1) begin
                r_packet_counter <= n_packet_counter;
                r_failsafe       <= n_failsafe;
                r_last_button    <= i_button_toggle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en.s1) begin
            r1_cnt <= n_packet_counter;
            r1_fs  <= n_failsafe;
            r1_rem <= !i_axis_6[rcf_pkg::AXIS_W-1];
        end
        if (w_en.s2) begin
            r2_cnt <= r1_cnt;
            r2_fs  <= r1_fs;
            r2_rem <= r1_rem;
        end
        if (w_en.s3) begin
            r3_cnt <= r2_cnt;
            r3_fs  <= r2_fs;
            r3_rem <= r2_rem;
        end
        if (w_en.s4) begin
            r4_cnt <= r3_cnt;
            r4_fs  <= r3_fs;
            r4_rem <= r3_rem;
            r_ch   <= w_lane_val;
        end
    end

    assign w_axes = {i_axis_7, i_axis_5, i_axis_4, i_axis_3,
                     i_axis_2, i_axis_1, i_axis_0};

    for (genvar l = 0; l < rcf_pkg::N_LANES; l++) begin : g_lane
        rcf_scale_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_axis  (w_axes[l]),
            .i_span  (w_span),
            .i_min   (r_ch_min),
            .o_value (w_lane_val[l])
        );
    end

    always_comb begin
        w_words[0] = r3_cnt;
        for (int l = 0; l < rcf_pkg::N_LANES; l++) begin
            w_words[l+1] = {{(rcf_pkg::WORD_W-rcf_pkg::CH_W){1'b0}}, w_lane_val[l]};
        end
        w_words[8] = {{(rcf_pkg::WORD_W-1){1'b0}}, r3_rem};
        w_words[9] = {{(rcf_pkg::WORD_W-1){1'b0}}, r3_fs};
    end

    rcf_crc_merge u_crc (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_words (w_words),
        .o_crc   (o_frame_crc)
    );

    assign o_out_valid     = r_v4;
    assign o_packet_number = r4_cnt;
    assign o_ch1_scaled    = r_ch[0];
    assign o_ch2_scaled    = r_ch[1];
    assign o_ch3_scaled    = r_ch[2];
    assign o_ch4_scaled    = r_ch[3];
    assign o_ch5_scaled    = r_ch[4];
    assign o_ch6_scaled    = r_ch[5];
    assign o_ch7_scaled    = r_ch[6];
    assign o_remote_flag   = r4_rem;
    assign o_failsafe_flag = r4_fs;

endmodule

`default_nettype wire

@@ rtl/rcf_chk.sv @@
// ---------------------------------------------------------------------------
// rcf_chk: port-level checks for the RC channel frame block
// Watches the handshakes and result fields over time; bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module rcf_chk (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic                         o_cfg_ready,
    input  wire logic                         i_cfg_index,
    input  wire logic [rcf_pkg::CH_W-1:0]     i_cfg_data,
    input  wire logic                         i_in_valid,
    input  wire logic                         o_in_ready,
    input  wire logic                         o_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [rcf_pkg::WORD_W-1:0]   o_packet_number,
    input  wire logic [rcf_pkg::CH_W-1:0]     o_ch1_scaled,
    input  wire logic [rcf_pkg::CH_W-1:0]     o_ch7_scaled,
    input  wire logic [rcf_pkg::WORD_W-1:0]   o_frame_crc
);

    logic [rcf_pkg::CH_W-1:0]   r_min;
    logic [rcf_pkg::CH_W-1:0]   r_max;
    logic [rcf_pkg::WORD_W-1:0] r_last_pn;
    logic                       r_seen;
    logic [2:0]                 r_inflight;
    logic                       w_in_acc;
    logic                       w_out_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= rcf_pkg::CH_MIN_RST;
            r_max      <= rcf_pkg::CH_MAX_RST;
            r_seen     <= 1'b0;
            r_last_pn  <= '0;
            r_inflight <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == rcf_pkg::CFG_CH_MIN) begin
                    r_min <= i_cfg_data;
                end else begin
                    r_max <= i_cfg_data;
                end
            end
            if (w_out_acc) begin
                r_seen    <= 1'b1;
                r_last_pn <= o_packet_number;
            end
            r_inflight <= r_inflight + {2'b0, w_in_acc} - {2'b0, w_out_acc};
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_inflight != 3'd0))
        else $error("result shown with no request in flight");

    a_pn_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_seen) |-> (o_packet_number == r_last_pn + 1'b1))
        else $error("packet number out of sequence");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_min <= r_max)) |->
        (o_ch1_scaled >= r_min && o_ch1_scaled <= r_max &&
         o_ch7_scaled >= r_min && o_ch7_scaled <= r_max))
        else $error("scaled channel outside min/max");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_frame_crc)))
        else $error("stalled result changed");

endmodule

bind rc_channel_frame_crc16 rcf_chk u_rcf_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready),
    .i_cfg_index     (i_cfg_index),
    .i_cfg_data      (i_cfg_data),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_packet_number (o_packet_number),
    .o_ch1_scaled    (o_ch1_scaled),
    .o_ch7_scaled    (o_ch7_scaled),
    .o_frame_crc     (o_frame_crc)
);

`default_nettype wire
